/* rtl/led_grid_command_decoder_assert.svh */
// ---------------------------------------------------------------------------
// LED grid command decoder assertion macros
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef LED_GRID_COMMAND_DECODER_ASSERT_SVH
`define LED_GRID_COMMAND_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LGCD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define LGCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lgcd_pkg.sv */
// ---------------------------------------------------------------------------
// LED grid command decoder package
// Request and response payload types and command decode constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgcd_pkg;

   // Command opcode, top two bits of the first byte of a frame
   typedef enum logic [1:0] {
      OP_MODE = 2'b00,
      OP_DATA = 2'b01,
      OP_CTRL = 2'b10,
      OP_ADDR = 2'b11
   } opcode_type;

   // Bit positions inside command bytes
   localparam int DATA_FIXED_BIT = 2;
   localparam int DATA_READ_BIT  = 1;
   localparam int CTRL_ON_BIT    = 3;

   localparam int ADDR_W = 4;

   typedef struct packed {
      logic              mode;
      logic              frame_start;
      logic [7:0]        bus_byte;
      logic [ADDR_W-1:0] scan_address;
   } req_type;

   typedef struct packed {
      logic [7:0]        scan_data;
      logic              ram_written;
      logic [ADDR_W-1:0] written_address;
      logic              byte_ignored;
      logic              display_on;
      logic [2:0]        brightness;
      logic [1:0]        grid_layout;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/lgcd_stream_if.sv */
// ---------------------------------------------------------------------------
// LED grid command decoder stream interface
// Valid/ready channel carrying one payload item per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lgcd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* rtl/lgcd_core.sv */
// ---------------------------------------------------------------------------
// LED grid command decoder core
// Holds display RAM and control state; decodes one request per advance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgcd_core #(
   parameter int GRID_COUNT = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  wire lgcd_pkg::req_type item,
   output lgcd_pkg::rsp_type     result
);

   localparam int RAM_DEPTH = 2 * GRID_COUNT;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);
   localparam logic [lgcd_pkg::ADDR_W:0] RAM_LIMIT = (lgcd_pkg::ADDR_W + 1)'(RAM_DEPTH);

   logic [7:0]                  ram_ff [RAM_DEPTH];
   logic [lgcd_pkg::ADDR_W-1:0] addr_ff, addr_in;
   logic                        fixed_ff, fixed_in;
   logic                        read_ff, read_in;
   logic                        takes_ff, takes_in;
   logic                        on_ff, on_in;
   logic [2:0]                  level_ff, level_in;
   logic [1:0]                  arr_ff, arr_in;

   logic                        wr_en;
   logic                        scan_hit;
   logic                        data_hit;
   lgcd_pkg::opcode_type        opcode;

   assign opcode   = lgcd_pkg::opcode_type'(item.bus_byte[7:6]);
   assign scan_hit = {1'b0, item.scan_address} < RAM_LIMIT;
   assign data_hit = {1'b0, addr_ff} < RAM_LIMIT;

   // Decode one request: next state and response fields
   always_comb begin
      addr_in  = addr_ff;
      fixed_in = fixed_ff;
      read_in  = read_ff;
      takes_in = takes_ff;
      on_in    = on_ff;
      level_in = level_ff;
      arr_in   = arr_ff;
      wr_en    = 1'b0;

      result.scan_data       = '0;
      result.ram_written     = 1'b0;
      result.written_address = '0;
      result.byte_ignored    = 1'b0;

      if (item.mode) begin
         // Scan read; beyond RAM reads zero
         if (scan_hit) begin
            result.scan_data = ram_ff[item.scan_address[RAM_AW-1:0]];
         end
      end else if (item.frame_start) begin
         unique case (opcode)
            lgcd_pkg::OP_MODE: begin
               arr_in   = item.bus_byte[1:0];
               takes_in = 1'b0;
            end
            lgcd_pkg::OP_DATA: begin
               fixed_in = item.bus_byte[lgcd_pkg::DATA_FIXED_BIT];
               read_in  = item.bus_byte[lgcd_pkg::DATA_READ_BIT];
               takes_in = 1'b1;
            end
            lgcd_pkg::OP_CTRL: begin
               level_in = item.bus_byte[2:0];
               on_in    = item.bus_byte[lgcd_pkg::CTRL_ON_BIT];
               takes_in = 1'b0;
            end
            lgcd_pkg::OP_ADDR: begin
               addr_in  = item.bus_byte[lgcd_pkg::ADDR_W-1:0];
               takes_in = 1'b1;
            end
            default: begin
               takes_in = takes_ff;
            end
         endcase
      end else if (!takes_ff) begin
         // Data byte outside a data or address frame
         result.byte_ignored = 1'b1;
      end else if (read_ff) begin
         // Read-back not supported: drop, address holds
         result.byte_ignored    = 1'b1;
         result.written_address = addr_ff;
      end else begin
         result.written_address = addr_ff;
         if (data_hit) begin
            wr_en              = 1'b1;
            result.ram_written = 1'b1;
         end else begin
            result.byte_ignored = 1'b1;
         end
         if (!fixed_ff) begin
            addr_in = addr_ff + 1'b1;
         end
      end

      result.display_on  = on_in;
      result.brightness  = level_in;
      result.grid_layout = arr_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff  <= '0;
         fixed_ff <= 1'b0;
         read_ff  <= 1'b0;
         takes_ff <= 1'b0;
         on_ff    <= 1'b0;
         level_ff <= '0;
         arr_ff   <= '0;
      end else if (advance) begin
         addr_ff  <= addr_in;
         fixed_ff <= fixed_in;
         read_ff  <= read_in;
         takes_ff <= takes_in;
         on_ff    <= on_in;
         level_ff <= level_in;
         arr_ff   <= arr_in;
      end
   end

   // Display RAM, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RAM_DEPTH; i++) begin
            ram_ff[i] <= '0;
         end
      end else if (advance && wr_en) begin
         ram_ff[addr_ff[RAM_AW-1:0]] <= item.bus_byte;
      end
   end

endmodule

`default_nettype wire

/* rtl/led_grid_command_decoder.sv */
// An accepted request is held in the input register, decoded into the output register
// and offered from there. Throughput: one request per cycle while responses are taken.
// A held response stops the decode stage; requests stall once both registers are full.
// Reset: synchronous, active high; clears display RAM, address, mode, brightness
// and enable state, and empties both pipeline registers.
// ---------------------------------------------------------------------------
// LED grid command decoder
// Serial command decoder for an LED grid controller with display RAM scan.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module led_grid_command_decoder #(
   parameter int GRID_COUNT = 7
) (
   input  wire logic     clock,
   input  wire logic     reset,
   lgcd_stream_if.sink   req_chan,
   lgcd_stream_if.source rsp_chan
);

   logic              in_valid_ff;
   lgcd_pkg::req_type in_item_ff;
   logic              out_valid_ff;
   lgcd_pkg::rsp_type out_rsp_ff;
   lgcd_pkg::rsp_type core_rsp;
   logic              advance;
   logic              req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = !in_valid_ff || advance;
   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_rsp_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_chan.payload;
      end
   end

   // Decode and state
   lgcd_core #(
      .GRID_COUNT (GRID_COUNT)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (core_rsp)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

endmodule

`default_nettype wire

/* rtl/lgcd_checker.sv */
// ---------------------------------------------------------------------------
// LED grid command decoder port checker
// Watches the top-level channels and flags inconsistent responses.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "led_grid_command_decoder_assert.svh"

module lgcd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire lgcd_pkg::rsp_type rsp_payload
);

   // Stalled response stays offered
   `LGCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   // Pipeline comes out of reset empty
   `LGCD_ASSERT_IMPLY(a_reset_empty, clock, reset, $past(reset), !rsp_valid, "response valid right after reset")

   // A byte is never both stored and ignored
   `LGCD_ASSERT_IMPLY(a_write_xor_drop, clock, reset, rsp_valid, !(rsp_payload.ram_written && rsp_payload.byte_ignored), "byte both written and ignored")

   // Scan data only appears on scan responses, which never write
   `LGCD_ASSERT_IMPLY(a_scan_clean, clock, reset, rsp_valid && (rsp_payload.scan_data != 8'd0), !rsp_payload.ram_written && !rsp_payload.byte_ignored && (rsp_payload.written_address == 4'd0), "scan response carries write status")

endmodule

bind led_grid_command_decoder lgcd_checker u_lgcd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

`default_nettype wire
